// ===== hdl/ngp_pkg.sv =====
// ----------------------------------------------------------------------------
// ngp_pkg: shared types and constants
// Widths, FSM encoding and the command/status bundles of the nested group
// proximal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ngp_pkg;

  localparam int MAX_LENGTH = 32;
  localparam int IDX_W      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int VAL_W      = 32;
  localparam int WGT_W      = 31;
  localparam int POS_W      = 5;
  localparam int FAC_W      = 17;
  localparam int QUO_W      = 16;
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = 32;
  localparam logic [FAC_W-1:0] ONE_Q16 = FAC_W'(65536);

  typedef enum logic [13:0] {
    S_LOAD     = 14'b00000000000001,
    S_SUM_RD   = 14'b00000000000010,
    S_SUM_SQ   = 14'b00000000000100,
    S_SUM_ACC  = 14'b00000000001000,
    S_ROOT     = 14'b00000000010000,
    S_DIV0     = 14'b00000000100000,
    S_DIV      = 14'b00000001000000,
    S_SC_RD    = 14'b00000010000000,
    S_SC_MUL   = 14'b00000100000000,
    S_SC_WR    = 14'b00001000000000,
    S_OUT_RD   = 14'b00010000000000,
    S_OUT_CAP  = 14'b00100000000000,
    S_OUT_HOLD = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic run_init;
    logic sq_cap;
    logic acc_add;
    logic k_inc;
    logic root_init;
    logic root_step;
    logic div_init;
    logic div_step;
    logic scale_init;
    logic sc_cap;
    logic sc_wr;
    logic next_j;
    logic out_init;
    logic out_cap;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic j_zero;
    logic root_last;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/ngp_if.sv =====
// ----------------------------------------------------------------------------
// ngp_in_if / ngp_out_if: stream channels
// Valid/ready channels carrying input elements and shrunken coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface ngp_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         value;
  logic [ngp_pkg::WGT_W-1:0]  weight;
  logic                       last;
  modport source (output valid, value, weight, last, input ready);
  modport sink   (input valid, value, weight, last, output ready);
endinterface

interface ngp_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [31:0]         coefficient;
  logic [ngp_pkg::POS_W-1:0]  position;
  logic                       final_flag;
  logic                       overflow;
  modport source (output valid, coefficient, position, final_flag, overflow, input ready);
  modport sink   (input valid, coefficient, position, final_flag, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/ngp_ram.sv =====
// ----------------------------------------------------------------------------
// ngp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ngp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/ngp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngp_ctrl: sequencing state machine
// Steps load, tail sum, square root, division, scaling and emit phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ngp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire ngp_pkg::sts_t sts,
  output ngp_pkg::cmd_t      cmd
);
  ngp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ngp_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ngp_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.run_init = 1'b1;
            state_next   = ngp_pkg::S_SUM_RD;
          end
        end
      end
      ngp_pkg::S_SUM_RD: state_next = ngp_pkg::S_SUM_SQ;
      ngp_pkg::S_SUM_SQ: begin
        cmd.sq_cap = 1'b1;
        state_next = ngp_pkg::S_SUM_ACC;
      end
      ngp_pkg::S_SUM_ACC: begin
        cmd.acc_add = 1'b1;
        if (sts.k_last) begin
          cmd.root_init = 1'b1;
          state_next    = ngp_pkg::S_ROOT;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ngp_pkg::S_SUM_RD;
        end
      end
      ngp_pkg::S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) state_next = ngp_pkg::S_DIV0;
      end
      ngp_pkg::S_DIV0: begin
        cmd.div_init = 1'b1;
        state_next   = ngp_pkg::S_DIV;
      end
      ngp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.scale_init = 1'b1;
          state_next     = ngp_pkg::S_SC_RD;
        end
      end
      ngp_pkg::S_SC_RD: state_next = ngp_pkg::S_SC_MUL;
      ngp_pkg::S_SC_MUL: begin
        cmd.sc_cap = 1'b1;
        state_next = ngp_pkg::S_SC_WR;
      end
      ngp_pkg::S_SC_WR: begin
        cmd.sc_wr = 1'b1;
        if (sts.k_last) begin
          if (sts.j_zero) begin
            cmd.out_init = 1'b1;
            state_next   = ngp_pkg::S_OUT_RD;
          end else begin
            cmd.next_j = 1'b1;
            state_next = ngp_pkg::S_SUM_RD;
          end
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ngp_pkg::S_SC_RD;
        end
      end
      ngp_pkg::S_OUT_RD: state_next = ngp_pkg::S_OUT_CAP;
      ngp_pkg::S_OUT_CAP: begin
        cmd.out_cap = 1'b1;
        state_next  = ngp_pkg::S_OUT_HOLD;
      end
      ngp_pkg::S_OUT_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.k_last) begin
            cmd.clr    = 1'b1;
            state_next = ngp_pkg::S_LOAD;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = ngp_pkg::S_OUT_RD;
          end
        end
      end
      default: state_next = ngp_pkg::S_LOAD;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/ngp_dp.sv =====
// ----------------------------------------------------------------------------
// ngp_dp: datapath
// Element stores, tail square accumulator, bit-serial square root and
// divider, scaling multiplier and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ngp_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ngp_pkg::cmd_t              cmd,
  output ngp_pkg::sts_t                   sts,
  input  wire logic [ngp_pkg::VAL_W-1:0]  in_value,
  input  wire logic [ngp_pkg::WGT_W-1:0]  in_weight,
  output logic      [ngp_pkg::VAL_W-1:0]  coefficient,
  output logic      [ngp_pkg::POS_W-1:0]  position,
  output logic                            final_flag,
  output logic                            overflow
);
  logic [ngp_pkg::CNT_W-1:0]  count, count_next;
  logic                       ovf;
  logic [ngp_pkg::IDX_W-1:0]  j, k;
  logic [ngp_pkg::SUM_W-1:0]  acc, sq;
  logic [ngp_pkg::SUM_W-1:0]  res, bitv;
  logic [ngp_pkg::ROOT_W-1:0] rem;
  logic [ngp_pkg::QUO_W-1:0]  quo;
  logic [3:0]                 div_cnt;
  logic                       sat;
  logic [48:0]                prod;
  logic                       sc_neg;

  logic                       full;
  logic [ngp_pkg::VAL_W-1:0]  v_rdata, v_wdata, mag;
  logic [ngp_pkg::WGT_W-1:0]  w_rdata;
  logic [ngp_pkg::IDX_W-1:0]  v_waddr;
  logic                       v_we;
  logic [ngp_pkg::SUM_W:0]    acc_sum, root_try;
  logic [ngp_pkg::ROOT_W:0]   rem2;
  logic [ngp_pkg::ROOT_W-1:0] norm;
  logic [ngp_pkg::FAC_W-1:0]  factor;
  logic [ngp_pkg::VAL_W-1:0]  scaled;

  assign full       = (count == ngp_pkg::CNT_W'(ngp_pkg::MAX_LENGTH));
  assign count_next = full ? count : count + 1'b1;
  assign mag        = v_rdata[ngp_pkg::VAL_W-1] ? (~v_rdata + 1'b1) : v_rdata;
  assign acc_sum    = {1'b0, acc} + {1'b0, sq};
  assign root_try   = {1'b0, res} + {1'b0, bitv};
  assign norm       = res[ngp_pkg::ROOT_W-1:0];
  assign rem2       = {rem, 1'b0};
  assign factor     = sat ? '0 : ngp_pkg::ONE_Q16 - ngp_pkg::FAC_W'(quo);
  assign scaled     = sc_neg ? (~prod[47:16] + 1'b1) : prod[47:16];

  assign v_we    = (cmd.load && !full) || cmd.sc_wr;
  assign v_waddr = cmd.sc_wr ? k : count[ngp_pkg::IDX_W-1:0];
  assign v_wdata = cmd.sc_wr ? scaled : in_value;

  assign sts.k_last    = (ngp_pkg::CNT_W'(k) + 1'b1 == count);
  assign sts.j_zero    = (j == '0);
  assign sts.root_last = bitv[0];
  assign sts.div_last  = (div_cnt == 4'd15);

  ngp_ram #(.WIDTH(ngp_pkg::VAL_W), .DEPTH(ngp_pkg::MAX_LENGTH)) u_value_ram (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .raddr(k),
    .rdata(v_rdata)
  );

  ngp_ram #(.WIDTH(ngp_pkg::WGT_W), .DEPTH(ngp_pkg::MAX_LENGTH)) u_weight_ram (
    .clk  (clk),
    .we   (cmd.load && !full),
    .waddr(count[ngp_pkg::IDX_W-1:0]),
    .wdata(in_weight),
    .raddr(j),
    .rdata(w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clr) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      count <= count_next;
      if (full) ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      j   <= ngp_pkg::IDX_W'(count_next - 1'b1);
      k   <= ngp_pkg::IDX_W'(count_next - 1'b1);
      acc <= '0;
    end else if (cmd.next_j) begin
      j   <= j - 1'b1;
      k   <= j - 1'b1;
      acc <= '0;
    end else if (cmd.scale_init) begin
      k <= j;
    end else if (cmd.out_init || cmd.clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
    if (cmd.sq_cap) sq <= {32'd0, mag} * {32'd0, mag};
    if (cmd.acc_add) acc <= acc_sum[ngp_pkg::SUM_W] ? '1 : acc_sum[ngp_pkg::SUM_W-1:0];
    if (cmd.root_init) begin
      res  <= '0;
      bitv <= ngp_pkg::SUM_W'(1) << (ngp_pkg::SUM_W - 2);
    end else if (cmd.root_step) begin
      bitv <= bitv >> 2;
      if ({1'b0, acc} >= root_try) begin
        acc <= acc - root_try[ngp_pkg::SUM_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
    end
    if (cmd.div_init) begin
      rem     <= {1'b0, w_rdata};
      sat     <= ({1'b0, w_rdata} >= norm);
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem2 >= {1'b0, norm}) begin
        rem <= ngp_pkg::ROOT_W'(rem2 - {1'b0, norm});
        quo <= {quo[ngp_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem2[ngp_pkg::ROOT_W-1:0];
        quo <= {quo[ngp_pkg::QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.sc_cap) begin
      prod   <= {17'd0, mag} * {32'd0, factor};
      sc_neg <= v_rdata[ngp_pkg::VAL_W-1];
    end
    if (cmd.out_cap) begin
      coefficient <= v_rdata;
      position    <= ngp_pkg::POS_W'(k);
      final_flag  <= sts.k_last;
      overflow    <= ovf;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/nested_group_prox.sv =====
// ----------------------------------------------------------------------------
// nested_group_prox: nested group-lasso proximal operator, Q16.16
// Loads a vector, shrinks nested tails from the top index down, emits it.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                     | Beat when
// load    | in  | value[32] s, weight[31], last               | valid & ready
// result  | out | coefficient[32] s, position[5], final_flag,  | valid & ready
//         |     | overflow                                    |
//
// Loading takes one element per cycle; load.ready is high only while loading.
// For each index j of an n-element run: a read/square/accumulate pass over the
// tail for the square sum, the bit-serial root, the division and a
// read/multiply/write pass over the tail for scaling; emitting reads, captures
// and holds each beat, and waits out result stalls.
// Synchronous reset returns to loading with an empty vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nested_group_prox (
  input  wire logic clk,
  input  wire logic rst,
  ngp_in_if.sink    load,
  ngp_out_if.source result
);
  ngp_pkg::cmd_t cmd;
  ngp_pkg::sts_t sts;
  logic [ngp_pkg::VAL_W-1:0] coef;

  ngp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (load.valid),
    .in_last  (load.last),
    .in_ready (load.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ngp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (load.value),
    .in_weight  (load.weight),
    .coefficient(coef),
    .position   (result.position),
    .final_flag (result.final_flag),
    .overflow   (result.overflow)
  );

  assign result.coefficient = coef;
endmodule
`default_nettype wire

// ===== hdl/ngp_checker.sv =====
// ----------------------------------------------------------------------------
// ngp_checker: port-level assertions
// Watches the top-level channels for sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ngp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic load_valid,
  input wire logic load_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_final
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(load_ready && res_valid))
    else $error("loading while emitting");

  a_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_final |=> load_ready && !res_valid)
    else $error("no return to loading after final beat");

  a_rst: assert property (@(posedge clk)
    rst |=> load_ready && !res_valid)
    else $error("reset did not return to loading");

  a_last: assert property (@(posedge clk) disable iff (rst)
    load_valid && load_ready |=> load_ready || !res_valid)
    else $error("result shown right after a load beat");
endmodule

bind nested_group_prox ngp_checker u_ngp_checker (
  .clk       (clk),
  .rst       (rst),
  .load_valid(load.valid),
  .load_ready(load.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_final (result.final_flag)
);
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for nested_group_prox
// Loads vectors of Q16.16 elements with weights, predicts the shrunken
// coefficients of every run and compares each result beat in order, under
// several phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic signed [31:0]          coefficient;
    logic [ngp_pkg::POS_W-1:0]   position;
    logic                        final_flag;
    logic                        overflow;
  } coef_t;

  typedef struct packed {
    logic signed [31:0]          value;
    logic [ngp_pkg::WGT_W-1:0]   weight;
    logic                        last;
    logic                        check;
    logic signed [31:0]          coefficient;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  ngp_in_if  load ();
  ngp_out_if result ();

  nested_group_prox dut (.clk(clk), .rst(rst), .load(load), .result(result));

  logic [31:0]               vec_value [ngp_pkg::MAX_LENGTH];
  logic [ngp_pkg::WGT_W-1:0] vec_weight [ngp_pkg::MAX_LENGTH];
  int               vec_count;
  logic             vec_dropped;
  coef_t            coef_queue [$];
  logic [31:0]      typed_queue [$];
  logic             typed_check [$];
  int               errors;
  int               send_idle;
  int               recv_stall;

  function automatic logic [63:0] magnitude(logic [31:0] v);
    logic [31:0] neg;
    neg = -v;
    return v[31] ? {32'd0, neg} : {32'd0, v};
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] shrink(logic [31:0] v, logic [31:0] factor);
    logic [63:0] prod;
    logic [31:0] r;
    prod = (magnitude(v) * 64'(factor)) >> 16;
    r = prod[31:0];
    return v[31] ? -r : r;
  endfunction

  task automatic shrink_tails_and_emit(input logic check, input logic [31:0] typed);
    logic [63:0] sum;
    logic [63:0] sq;
    logic [63:0] norm;
    logic [63:0] ratio;
    logic [31:0] factor;
    coef_t c;
    for (int j = vec_count - 1; j >= 0; j--) begin
      sum = 0;
      for (int k = j; k < vec_count; k++) begin
        sq = magnitude(vec_value[k]) * magnitude(vec_value[k]);
        sum = (sum + sq < sum) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
      end
      norm = floor_root(sum);
      if (norm == 0) factor = 0;
      else begin
        ratio = (64'(vec_weight[j]) << 16) / norm;
        factor = (ratio >= 65536) ? 32'd0 : 32'(65536 - ratio);
      end
      for (int k = j; k < vec_count; k++) vec_value[k] = shrink(vec_value[k], factor);
    end
    for (int k = 0; k < vec_count; k++) begin
      c.coefficient = vec_value[k];
      c.position    = ngp_pkg::POS_W'(k);
      c.final_flag  = (k + 1 == vec_count);
      c.overflow    = vec_dropped;
      coef_queue.push_back(c);
      typed_queue.push_back(typed);
      typed_check.push_back(check && k == 0);
    end
    vec_count = 0;
    vec_dropped = 1'b0;
  endtask

  task automatic absorb(input row_t r);
    if (vec_count < ngp_pkg::MAX_LENGTH) begin
      vec_value[vec_count]  = r.value;
      vec_weight[vec_count] = r.weight;
      vec_count++;
    end else begin
      vec_dropped = 1'b1;
    end
    if (r.last) shrink_tails_and_emit(r.check, r.coefficient);
  endtask

  task automatic send(input row_t r);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      load.valid <= 1'b0;
      @(posedge clk);
    end
    load.valid  <= 1'b1;
    load.value  <= r.value;
    load.weight <= r.weight;
    load.last   <= r.last;
    do @(posedge clk); while (!load.ready);
    absorb(r);
  endtask

  task automatic send_vector(input int len, input int mode);
    row_t r;
    for (int i = 0; i < len; i++) begin
      r = '0;
      case (mode)
        0: r.value = $urandom;
        1: r.value = $signed($urandom_range(131072)) - 65536;
        default: r.value = $signed($urandom_range(8388608)) - 4194304;
      endcase
      r.weight = ($urandom_range(3) == 0) ? ngp_pkg::WGT_W'($urandom) :
                 ngp_pkg::WGT_W'($urandom_range(196608));
      r.last = (i == len - 1);
      send(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) result.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    if (!rst && result.valid && result.ready) begin
      if (coef_queue.size() == 0) begin
        $display("%0t unexpected beat: coefficient %h position %0d", $time,
                 result.coefficient, result.position);
        errors++;
      end else begin
        if ({result.coefficient, result.position, result.final_flag, result.overflow}
            !== coef_queue[0]) begin
          $display("%0t expected %h/%0d/%b/%b actual %h/%0d/%b/%b", $time,
                   coef_queue[0].coefficient, coef_queue[0].position,
                   coef_queue[0].final_flag, coef_queue[0].overflow,
                   result.coefficient, result.position, result.final_flag,
                   result.overflow);
          errors++;
        end
        if (typed_check[0] && result.coefficient !== typed_queue[0]) begin
          $display("%0t expected %h actual %h", $time, typed_queue[0], result.coefficient);
          errors++;
        end
        void'(coef_queue.pop_front());
        void'(typed_queue.pop_front());
        void'(typed_check.pop_front());
      end
    end
  end

  initial begin
    #2000000;
    $display("nested_group_prox: mismatch");
    $finish;
  end

  row_t directed [] = '{
    '{32'sh0001_0000, 31'h0000_8000, 1'b1, 1'b1, 32'sh0000_8000},
    '{32'sh0000_0000, 31'h0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
    '{32'sh7FFF_FFFF, 31'h0000_0000, 1'b1, 1'b1, 32'sh7FFF_FFFF},
    '{32'sh8000_0000, 31'h0000_0000, 1'b1, 1'b1, 32'sh8000_0000},
    '{32'sh8000_0000, 31'h7FFF_FFFF, 1'b1, 1'b1, 32'shFFFF_8000},
    '{32'shFFFF_0000, 31'h0001_0000, 1'b1, 1'b1, 32'sh0000_0000},
    '{32'sh0003_0000, 31'h0001_0000, 1'b0, 1'b0, 32'sh0},
    '{32'shFFFC_0000, 31'h0000_8000, 1'b1, 1'b0, 32'sh0},
    '{32'sh7FFF_FFFF, 31'h0000_0001, 1'b0, 1'b0, 32'sh0},
    '{32'sh8000_0000, 31'h0000_0001, 1'b0, 1'b0, 32'sh0},
    '{32'sh7FFF_FFFF, 31'h0000_0001, 1'b1, 1'b0, 32'sh0}
  };

  initial begin
    row_t r;
    errors = 0;
    send_idle = 0;
    recv_stall = 0;
    vec_count = 0;
    vec_dropped = 1'b0;
    load.valid = 1'b0;
    load.value = '0;
    load.weight = '0;
    load.last = 1'b0;
    result.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send(directed[i]);
    // overflow: 34 elements, last one dropped too
    for (int i = 0; i < 34; i++) begin
      r = '0;
      r.value = $signed($urandom_range(131072)) - 65536;
      r.weight = ngp_pkg::WGT_W'($urandom_range(65536));
      r.last = (i == 33);
      send(r);
    end
    load.valid <= 1'b0;
    wait (coef_queue.size() == 0);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle  = (phase == 1 || phase == 3) ? ((phase == 3) ? 17 : 46) : 0;
      recv_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 17 : 46) : 0;
      for (int v = 0; v < 9; v++) begin
        send_vector((v == 8 && phase == 0) ? 32 : $urandom_range(1, 13), $urandom_range(2));
        if (v == 4) begin
          load.valid <= 1'b0;
          wait (coef_queue.size() == 0);
        end
      end
    end
    load.valid <= 1'b0;
    wait (coef_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("nested_group_prox: match");
    else $display("nested_group_prox: mismatch");
    $finish;
  end
endmodule
